>>> design/eave_pkg.sv
// Shared types and constants of the encoder angle and velocity estimator.
package eave_pkg;

    localparam int COUNT_W = 12;
    localparam int TIME_W  = 32;
    localparam int TAU_W   = 16;
    localparam int ANGLE_W = 19;
    localparam int VEL_W   = 32;
    localparam int PROD_W  = 64;

    localparam logic [TAU_W-1:0] TAU_RESET  = 16'd2000;
    // 2*pi in Q32
    localparam logic [34:0]      TWO_PI_Q32 = 35'h6487ED511;
    // 2*pi*16e6 in Q8 (counts to rad/s in Q16.16 with dt in microseconds)
    localparam logic [34:0]      VEL_K_Q8   = 35'd25735927018;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ADVANCE = 2'd1,
        ST_READ_FAIL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_EVAL,
        OP_FIRST,
        OP_MUL1,
        OP_ADD1,
        OP_DIV1,
        OP_VEL,
        OP_MUL2,
        OP_ADD2,
        OP_DIV2,
        OP_UPDATE
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    out_load;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic failed;
        logic have_ref;
        logic dt_pos;
        logic div_busy;
    } t_dp_stat;

endpackage

>>> design/eave_div.sv
// Iterative restoring divider: 32 quotient bits, one bit per cycle.
module eave_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rem_init,
    input  logic [31:0] i_low,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import eave_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_den;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic        take;

    assign shifted = {r_rem, r_low[31]};
    assign trial   = shifted - {1'b0, r_den};
    assign take    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_low <= i_low;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? trial[31:0] : shifted[31:0];
            // quotient bits shift in as dividend bits shift out
            r_low <= {r_low[30:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_low;

endmodule

>>> design/eave_dp.sv
// Datapath: estimator state, multiplies, divider operands and the output word register.
module eave_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  eave_pkg::t_dp_cmd           i_cmd,
    output eave_pkg::t_dp_stat          o_stat,
    input  logic                        i_cfg_wr_en,
    input  logic [15:0]                 i_cfg_wr_data,
    input  logic [15:0]                 i_raw_reading,
    input  logic [31:0]                 i_sample_time_us,
    input  logic                        i_read_failed,
    output logic [18:0]                 o_angle_q16,
    output logic signed [31:0]          o_velocity_q16,
    output logic [1:0]                  o_status
);
    import eave_pkg::*;

    // configuration and estimator state
    logic [TAU_W-1:0]          r_tau;
    logic                      r_have_ref;
    logic [COUNT_W-1:0]        r_ref_count;
    logic [TIME_W-1:0]         r_ref_time;
    logic signed [VEL_W-1:0]   r_est;

    // current word
    logic [COUNT_W-1:0]        r_count;
    logic [TIME_W-1:0]         r_time;
    logic                      r_failed;

    // working registers
    logic [ANGLE_W-1:0]        r_angle;
    logic [TIME_W-1:0]         r_dt;
    logic                      r_dneg;
    logic [COUNT_W-1:0]        r_dmag;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_sat;
    logic                      r_diff_neg;
    logic [31:0]               r_diff_mag;
    logic [31:0]               r_den;

    // output word
    logic [ANGLE_W-1:0]        r_o_angle;
    logic signed [VEL_W-1:0]   r_o_vel;
    logic [1:0]                r_o_status;

    logic [46:0]               ang_prod;
    logic [46:0]               ang_sum;
    logic signed [12:0]        d_raw;
    logic signed [13:0]        d_ext;
    logic signed [13:0]        d_wrap;
    logic [13:0]               d_abs;
    logic [6:0]                vel_high;
    logic                      div_start;
    logic [31:0]               div_rem;
    logic [31:0]               div_low;
    logic [31:0]               div_den;
    logic                      div_busy;
    logic [31:0]               quot;
    logic [31:0]               v_val;
    logic [32:0]               diff;
    logic [32:0]               diff_abs;

    assign ang_prod = 47'(r_count) * 47'(TWO_PI_Q32);
    assign ang_sum  = ang_prod + 47'(1 << 27);

    // count difference wrapped into one half turn either way
    assign d_raw = $signed({1'b0, r_count}) - $signed({1'b0, r_ref_count});
    assign d_ext = 14'(d_raw);
    always_comb begin
        if (d_ext > 14'sd2048) begin
            d_wrap = d_ext - 14'sd4096;
        end else if (d_ext < -14'sd2048) begin
            d_wrap = d_ext + 14'sd4096;
        end else begin
            d_wrap = d_ext;
        end
    end
    assign d_abs = d_wrap[13] ? 14'(-d_wrap) : 14'(d_wrap);

    // bits of the first dividend above the 32 low ones
    assign vel_high = r_prod[46:40];

    always_comb begin
        div_start = 1'b0;
        div_rem   = {25'd0, vel_high};
        div_low   = r_prod[39:8];
        div_den   = r_dt;
        case (i_cmd.op)
            OP_DIV1: begin
                div_start = 1'b1;
            end
            OP_DIV2: begin
                div_start = 1'b1;
                div_rem   = r_prod[63:32];
                div_low   = r_prod[31:0];
                div_den   = r_den;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    eave_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem),
        .i_low      (div_low),
        .i_den      (div_den),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // instantaneous velocity with saturation
    always_comb begin
        if (r_dneg) begin
            v_val = (r_sat || quot > 32'h8000_0000) ? 32'h8000_0000 : 32'(~quot + 32'd1);
        end else begin
            v_val = (r_sat || quot[31]) ? 32'h7FFF_FFFF : quot;
        end
    end
    assign diff     = {v_val[31], v_val} - {r_est[31], r_est};
    assign diff_abs = diff[32] ? 33'(~diff + 33'd1) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau       <= TAU_RESET;
            r_have_ref  <= 1'b0;
            r_ref_count <= '0;
            r_ref_time  <= '0;
            r_est       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tau <= i_cfg_wr_data;
            end
            case (i_cmd.op)
                OP_FIRST: begin
                    r_have_ref  <= 1'b1;
                    r_ref_count <= r_count;
                    r_ref_time  <= r_time;
                    r_est       <= '0;
                end
                OP_UPDATE: begin
                    r_ref_count <= r_count;
                    r_ref_time  <= r_time;
                    r_est       <= r_diff_neg ? r_est - $signed(quot) : r_est + $signed(quot);
                end
                default: begin
                    r_have_ref <= r_have_ref;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_count  <= i_raw_reading[COUNT_W-1:0];
                r_time   <= i_sample_time_us;
                r_failed <= i_read_failed;
            end
            OP_EVAL: begin
                r_angle <= ang_sum[46:28];
                r_dt    <= r_time - r_ref_time;
                r_dneg  <= d_wrap[13];
                r_dmag  <= d_abs[COUNT_W-1:0];
            end
            OP_MUL1: begin
                r_prod <= 64'(r_dmag) * 64'(VEL_K_Q8);
            end
            OP_ADD1: begin
                // half the divisor, dt*256/2, for rounding
                r_prod <= r_prod + {25'd0, r_dt, 7'd0};
            end
            OP_DIV1: begin
                // quotient would not fit 32 bits: saturate
                r_sat <= ({25'd0, vel_high} >= r_dt);
            end
            OP_VEL: begin
                r_diff_neg <= diff[32];
                r_diff_mag <= diff_abs[31:0];
                r_den      <= {16'd0, r_tau} + r_dt;
            end
            OP_MUL2: begin
                r_prod <= 64'(r_diff_mag) * 64'(r_dt);
            end
            OP_ADD2: begin
                r_prod <= r_prod + {33'd0, r_den[31:1]};
            end
            default: begin
                r_count <= r_count;
            end
        endcase
        if (i_cmd.out_load) begin
            r_o_angle  <= r_failed ? '0 : r_angle;
            r_o_vel    <= r_est;
            r_o_status <= i_cmd.status;
        end
    end

    assign o_stat.failed   = r_failed;
    assign o_stat.have_ref = r_have_ref;
    assign o_stat.dt_pos   = (r_dt != '0) && !r_dt[31];
    assign o_stat.div_busy = div_busy;

    assign o_angle_q16    = r_o_angle;
    assign o_velocity_q16 = r_o_vel;
    assign o_status       = r_o_status;

endmodule

>>> design/eave_ctrl.sv
// Controller: sequences one word through the datapath and owns the output valid.
module eave_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  eave_pkg::t_dp_stat  i_stat,
    output eave_pkg::t_dp_cmd   o_cmd
);
    import eave_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_MUL1,
        S_ADD1,
        S_DIV1,
        S_WAIT1,
        S_VEL,
        S_MUL2,
        S_ADD2,
        S_DIV2,
        S_WAIT2,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_status r_code;
    t_status n_code;

    always_comb begin
        n_state      = r_state;
        n_code       = r_code;
        o_cmd.op     = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_cmd.status = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.op = OP_EVAL;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.failed) begin
                    n_code  = ST_READ_FAIL;
                    n_state = S_FINISH;
                end else if (!i_stat.have_ref) begin
                    o_cmd.op = OP_FIRST;
                    n_code   = ST_OK;
                    n_state  = S_FINISH;
                end else if (!i_stat.dt_pos) begin
                    n_code  = ST_NO_ADVANCE;
                    n_state = S_FINISH;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = S_ADD1;
            end
            S_ADD1: begin
                o_cmd.op = OP_ADD1;
                n_state  = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.op = OP_DIV1;
                n_state  = S_WAIT1;
            end
            S_WAIT1: begin
                if (!i_stat.div_busy) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                o_cmd.op = OP_VEL;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_ADD2;
            end
            S_ADD2: begin
                o_cmd.op = OP_ADD2;
                n_state  = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.op = OP_DIV2;
                n_state  = S_WAIT2;
            end
            S_WAIT2: begin
                if (!i_stat.div_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> design/encoder_angle_velocity_estimator.sv
// Top level of the encoder angle and filtered velocity estimator.
//
// Input channel: i_valid / o_stall carry one word of raw encoder reading
// (low 12 bits used), microsecond timestamp and bus failure flag.
// Output channel: o_valid / i_stall carry angle (Q3.16 rad), filtered
// velocity (Q16.16 rad/s) and status for every input word.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the filter time
// constant (microseconds) at the same edge; reset value 2000.
// Sequence: a normal sample passes decode (EVAL, DECIDE), the velocity
// division (MUL1, ADD1, DIV1, WAIT1), the filter-step division (VEL, MUL2,
// ADD2, DIV2, WAIT2) and UPDATE before FINISH loads the output register;
// a failed read, the first sample or a timestamp that does not advance goes
// from DECIDE straight to FINISH. The next word is accepted after the load.
// Throughput: one word at a time; o_stall is high while a word is in work.
// A finished word waits in the output register while the next word is
// accepted; if the receiver still stalls when the next result is ready,
// the block holds that result and keeps o_stall high.
// Reset (synchronous, i_rst_n low): no reference sample, estimate zero,
// time constant 2000, output empty.
module encoder_angle_velocity_estimator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_raw_reading,
    input  logic [31:0]        i_sample_time_us,
    input  logic               i_read_failed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [18:0]        o_angle_q16,
    output logic signed [31:0] o_velocity_q16,
    output logic [1:0]         o_status
);
    import eave_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    eave_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    eave_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_raw_reading    (i_raw_reading),
        .i_sample_time_us (i_sample_time_us),
        .i_read_failed    (i_read_failed),
        .o_angle_q16      (o_angle_q16),
        .o_velocity_q16   (o_velocity_q16),
        .o_status         (o_status)
    );

endmodule

>>> design/eave_checker.sv
// Port-level checks of the estimator, bound to the top level.
module eave_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [18:0]        o_angle_q16,
    input logic signed [31:0] o_velocity_q16,
    input logic [1:0]         o_status
);
    import eave_pkg::*;

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_angle_q16) && $stable(o_velocity_q16)
                              && $stable(o_status))
        else $error("stalled output word changed");

    // a failed read reports no angle
    a_fail_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_READ_FAIL) |-> (o_angle_q16 == '0))
        else $error("angle reported on failed read");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_q16 <= 19'd411774))
        else $error("angle above one turn");

endmodule

bind encoder_angle_velocity_estimator eave_checker u_eave_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_angle_q16    (o_angle_q16),
    .o_velocity_q16 (o_velocity_q16),
    .o_status       (o_status)
);
